FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tner_pkg.sv
// Shared constants, codes and interface structs of the note event recorder.
package tner_pkg;

  localparam int CAPACITY  = 64;
  localparam int GAP_DEPTH = CAPACITY - 1;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int NOTE_W    = 16;
  localparam logic [TIME_W-1:0] SPAN_LIMIT = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_BEGIN = 3'd2,
    CMD_END   = 3'd3,
    CMD_PLAY  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED      = 3'd0,
    ST_STARTED       = 3'd1,
    ST_STOPPED_NOTES = 3'd2,
    ST_STOPPED_EMPTY = 3'd3,
    ST_ZERO_DUR      = 3'd4,
    ST_TOO_LONG      = 3'd5,
    ST_FULL          = 3'd6,
    ST_IGNORED       = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SUB_BEGIN,
    S_SUB_END,
    S_SUB_DUR,
    S_SUB_GAP,
    S_COMMIT,
    S_RESP,
    S_PLAY_RD,
    S_PLAY_OUT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              zero;
    logic              over;
  } alu_rsp_t;

  typedef struct packed {
    logic              we_entry;
    logic [IDX_W-1:0]  entry_addr;
    logic [NOTE_W-1:0] note;
    logic [DUR_W-1:0]  dur;
    logic              we_gap;
    logic [IDX_W-1:0]  gap_addr;
    logic [DUR_W-1:0]  gap;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } store_req_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [DUR_W-1:0]  dur;
    logic [DUR_W-1:0]  gap;
  } store_rsp_t;

endpackage

FILE: sv/timed_note_event_recorder.sv
// Top level of the timed note event recorder.
// Start, stop and ignored events go from dispatch straight to the result; note begin takes one
// subtractor pass, note end three passes through the one subtractor, then commit.
// Playback of n <= CAPACITY entries: each is read from the store, then shown until taken.
// The input stalls until the last result is taken and reopens in the next cycle; stalls add.
// Reset (rst, synchronous) clears control and offsets; stores hold no reset value.
module timed_note_event_recorder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         command,
  input  logic [tner_pkg::TIME_W-1:0]        time_ms,
  input  logic signed [tner_pkg::NOTE_W-1:0] note,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic [2:0]                         status,
  output logic                               recording,
  output logic [tner_pkg::CNT_W-1:0]         count,
  output logic signed [tner_pkg::NOTE_W-1:0] out_note,
  output logic [tner_pkg::DUR_W-1:0]         duration,
  output logic [tner_pkg::DUR_W-1:0]         gap,
  output logic                               last,
  output logic                               stop_sound
);

  logic [tner_pkg::TIME_W-1:0] alu_a;
  logic [tner_pkg::TIME_W-1:0] alu_b;
  tner_pkg::alu_rsp_t          alu_rsp;
  tner_pkg::store_req_t        store_req;
  tner_pkg::store_rsp_t        store_rsp;

  tner_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .rsp (alu_rsp)
  );

  tner_store u_store (
    .clk (clk),
    .req (store_req),
    .rsp (store_rsp)
  );

  tner_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .time_ms    (time_ms),
    .note       (note),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .status     (status),
    .recording  (recording),
    .count      (count),
    .out_note   (out_note),
    .duration   (duration),
    .gap        (gap),
    .last       (last),
    .stop_sound (stop_sound),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_rsp    (alu_rsp),
    .store_req  (store_req),
    .store_rsp  (store_rsp)
  );

endmodule

FILE: sv/tner_alu.sv
// Shared subtract and range-compare unit used by every offset step.
module tner_alu (
  input  logic [tner_pkg::TIME_W-1:0] a,
  input  logic [tner_pkg::TIME_W-1:0] b,
  output tner_pkg::alu_rsp_t          rsp
);

  logic [tner_pkg::TIME_W-1:0] diff;

  // Modulo 2^32 difference, as the timestamps wrap.
  assign diff     = a - b;
  assign rsp.diff = diff;
  assign rsp.zero = (diff == '0);
  assign rsp.over = (diff > tner_pkg::SPAN_LIMIT);

endmodule

FILE: sv/tner_store.sv
// Note, duration and gap memories with registered read.
module tner_store (
  input  logic                  clk,
  input  tner_pkg::store_req_t  req,
  output tner_pkg::store_rsp_t  rsp
);

  logic [tner_pkg::NOTE_W-1:0] note_mem [tner_pkg::CAPACITY];
  logic [tner_pkg::DUR_W-1:0]  dur_mem  [tner_pkg::CAPACITY];
  logic [tner_pkg::DUR_W-1:0]  gap_mem  [tner_pkg::GAP_DEPTH];
  logic                        gap_in_range;

  assign gap_in_range = ({1'b0, req.raddr} < (tner_pkg::IDX_W + 1)'(tner_pkg::GAP_DEPTH));

  always_ff @(posedge clk) begin
    if (req.we_entry) begin
      note_mem[req.entry_addr] <= req.note;
      dur_mem[req.entry_addr]  <= req.dur;
    end
    if (req.we_gap) begin
      gap_mem[req.gap_addr] <= req.gap;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rsp.note <= note_mem[req.raddr];
      rsp.dur  <= dur_mem[req.raddr];
      // The final entry has no gap slot; its gap is forced to zero anyway.
      if (gap_in_range) begin
        rsp.gap <= gap_mem[req.raddr];
      end else begin
        rsp.gap <= '0;
      end
    end
  end

endmodule

FILE: sv/tner_ctrl.sv
// Sequencer: decodes events, steps the shared subtractor, drives playback.
module tner_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         command,
  input  logic [tner_pkg::TIME_W-1:0]        time_ms,
  input  logic signed [tner_pkg::NOTE_W-1:0] note,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic [2:0]                         status,
  output logic                               recording,
  output logic [tner_pkg::CNT_W-1:0]         count,
  output logic signed [tner_pkg::NOTE_W-1:0] out_note,
  output logic [tner_pkg::DUR_W-1:0]         duration,
  output logic [tner_pkg::DUR_W-1:0]         gap,
  output logic                               last,
  output logic                               stop_sound,
  output logic [tner_pkg::TIME_W-1:0]        alu_a,
  output logic [tner_pkg::TIME_W-1:0]        alu_b,
  input  tner_pkg::alu_rsp_t                 alu_rsp,
  output tner_pkg::store_req_t               store_req,
  input  tner_pkg::store_rsp_t               store_rsp
);

  tner_pkg::state_t  state, state_next;
  tner_pkg::status_e status_r;

  logic [2:0]                  cmd_r;
  logic [tner_pkg::TIME_W-1:0] now_r;
  logic [tner_pkg::NOTE_W-1:0] note_r;

  logic                        rec;
  logic [tner_pkg::TIME_W-1:0] start_time;
  logic [tner_pkg::TIME_W-1:0] note_start_offset;
  logic [tner_pkg::TIME_W-1:0] previous_end_offset;
  logic [tner_pkg::NOTE_W-1:0] current_note_code;
  logic [tner_pkg::CNT_W-1:0]  stored_count;
  logic                        snd;

  logic [tner_pkg::TIME_W-1:0] end_off;
  logic [tner_pkg::DUR_W-1:0]  dur_r;
  logic [tner_pkg::DUR_W-1:0]  gap_r;
  logic                        dur_zero;
  logic                        dur_over;
  logic                        gap_over;
  logic [tner_pkg::IDX_W-1:0]  play_idx;

  logic                        is_full;
  logic                        will_fill;
  logic                        commit_ok;
  logic                        play_last;
  logic [tner_pkg::IDX_W-1:0]  wr_idx;

  assign wr_idx    = stored_count[tner_pkg::IDX_W-1:0];
  assign is_full   = (stored_count >= tner_pkg::CNT_W'(tner_pkg::CAPACITY));
  assign will_fill = ((stored_count + 1'b1) == tner_pkg::CNT_W'(tner_pkg::CAPACITY));
  assign commit_ok = !dur_zero && !dur_over && !is_full &&
                     !((stored_count != '0) && gap_over);
  assign play_last = ((tner_pkg::CNT_W'(play_idx) + 1'b1) == stored_count);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tner_pkg::S_IDLE: begin
        if (in_valid) state_next = tner_pkg::S_DISPATCH;
      end
      tner_pkg::S_DISPATCH: begin
        state_next = tner_pkg::S_RESP;
        if (cmd_r == tner_pkg::CMD_BEGIN && rec) begin
          state_next = tner_pkg::S_SUB_BEGIN;
        end else if (cmd_r == tner_pkg::CMD_END && rec) begin
          state_next = tner_pkg::S_SUB_END;
        end else if (cmd_r == tner_pkg::CMD_PLAY && !rec && stored_count != '0) begin
          state_next = tner_pkg::S_PLAY_RD;
        end
      end
      tner_pkg::S_SUB_BEGIN: state_next = tner_pkg::S_RESP;
      tner_pkg::S_SUB_END:   state_next = tner_pkg::S_SUB_DUR;
      tner_pkg::S_SUB_DUR:   state_next = tner_pkg::S_SUB_GAP;
      tner_pkg::S_SUB_GAP:   state_next = tner_pkg::S_COMMIT;
      tner_pkg::S_COMMIT:    state_next = tner_pkg::S_RESP;
      tner_pkg::S_RESP: begin
        if (!out_stall) state_next = tner_pkg::S_IDLE;
      end
      tner_pkg::S_PLAY_RD:   state_next = tner_pkg::S_PLAY_OUT;
      tner_pkg::S_PLAY_OUT: begin
        if (!out_stall) begin
          state_next = play_last ? tner_pkg::S_IDLE : tner_pkg::S_PLAY_RD;
        end
      end
      default: state_next = tner_pkg::S_IDLE;
    endcase
  end

  // Outputs, operand select and store requests.
  always_comb begin
    in_stall   = (state != tner_pkg::S_IDLE);
    out_valid  = 1'b0;
    kind       = 1'b0;
    status     = tner_pkg::ST_ACCEPTED;
    recording  = rec;
    count      = stored_count;
    out_note   = '0;
    duration   = '0;
    gap        = '0;
    last       = 1'b0;
    stop_sound = 1'b0;
    alu_a      = now_r;
    alu_b      = start_time;

    store_req            = '0;
    store_req.entry_addr = wr_idx;
    store_req.note       = current_note_code;
    store_req.dur        = dur_r;
    store_req.gap_addr   = wr_idx - 1'b1;
    store_req.gap        = gap_r;
    store_req.raddr      = play_idx;

    unique case (state)
      tner_pkg::S_SUB_DUR: begin
        alu_a = end_off;
        alu_b = note_start_offset;
      end
      tner_pkg::S_SUB_GAP: begin
        alu_a = note_start_offset;
        alu_b = previous_end_offset;
      end
      tner_pkg::S_COMMIT: begin
        store_req.we_entry = commit_ok;
        store_req.we_gap   = commit_ok && (stored_count != '0);
      end
      tner_pkg::S_RESP: begin
        out_valid  = 1'b1;
        status     = status_r;
        last       = 1'b1;
        stop_sound = snd;
      end
      tner_pkg::S_PLAY_RD: begin
        store_req.re = 1'b1;
      end
      tner_pkg::S_PLAY_OUT: begin
        out_valid = 1'b1;
        kind      = 1'b1;
        out_note  = store_rsp.note;
        duration  = store_rsp.dur;
        gap       = play_last ? '0 : store_rsp.gap;
        last      = play_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= tner_pkg::S_IDLE;
      rec                 <= 1'b0;
      start_time          <= '0;
      note_start_offset   <= '0;
      previous_end_offset <= '0;
      current_note_code   <= '1;
      stored_count        <= '0;
      snd                 <= 1'b0;
      status_r            <= tner_pkg::ST_IGNORED;
      play_idx            <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        tner_pkg::S_DISPATCH: begin
          snd      <= 1'b0;
          play_idx <= '0;
          status_r <= tner_pkg::ST_IGNORED;
          unique case (cmd_r)
            tner_pkg::CMD_START: begin
              if (!rec) begin
                stored_count <= '0;
                rec          <= 1'b1;
                start_time   <= now_r;
                status_r     <= tner_pkg::ST_STARTED;
              end
            end
            tner_pkg::CMD_STOP: begin
              if (rec) begin
                rec      <= 1'b0;
                status_r <= (stored_count != '0) ? tner_pkg::ST_STOPPED_NOTES
                                                 : tner_pkg::ST_STOPPED_EMPTY;
              end
            end
            tner_pkg::CMD_BEGIN: begin
              if (rec) status_r <= tner_pkg::ST_ACCEPTED;
            end
            default: begin
            end
          endcase
        end
        tner_pkg::S_SUB_BEGIN: begin
          note_start_offset <= alu_rsp.diff;
          current_note_code <= note_r;
        end
        tner_pkg::S_COMMIT: begin
          priority if (dur_zero) begin
            status_r <= tner_pkg::ST_ZERO_DUR;
          end else if (dur_over) begin
            rec      <= 1'b0;
            status_r <= tner_pkg::ST_TOO_LONG;
          end else if (is_full) begin
            rec      <= 1'b0;
            status_r <= tner_pkg::ST_FULL;
          end else if (stored_count != '0 && gap_over) begin
            rec      <= 1'b0;
            status_r <= tner_pkg::ST_TOO_LONG;
          end else begin
            previous_end_offset <= end_off;
            stored_count        <= stored_count + 1'b1;
            if (will_fill) begin
              rec      <= 1'b0;
              snd      <= 1'b1;
              status_r <= tner_pkg::ST_FULL;
            end else begin
              status_r <= tner_pkg::ST_ACCEPTED;
            end
          end
        end
        tner_pkg::S_PLAY_OUT: begin
          if (!out_stall && !play_last) play_idx <= play_idx + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Event capture and subtractor results; payload only, no reset.
  always_ff @(posedge clk) begin
    if (state == tner_pkg::S_IDLE && in_valid) begin
      cmd_r  <= command;
      now_r  <= time_ms;
      note_r <= note;
    end
    if (state == tner_pkg::S_SUB_END) begin
      end_off <= alu_rsp.diff;
    end
    if (state == tner_pkg::S_SUB_DUR) begin
      dur_r    <= alu_rsp.diff[tner_pkg::DUR_W-1:0];
      dur_zero <= alu_rsp.zero;
      dur_over <= alu_rsp.over;
    end
    if (state == tner_pkg::S_SUB_GAP) begin
      gap_r    <= alu_rsp.diff[tner_pkg::DUR_W-1:0];
      gap_over <= alu_rsp.over;
    end
  end

endmodule

FILE: sv/tner_checker.sv
// Port-level checks of the recorder, bound to the top level.
`include "assert_macros.svh"

module tner_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [2:0]                         command,
  input logic [tner_pkg::TIME_W-1:0]        time_ms,
  input logic signed [tner_pkg::NOTE_W-1:0] note,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               kind,
  input logic [2:0]                         status,
  input logic                               recording,
  input logic [tner_pkg::CNT_W-1:0]         count,
  input logic signed [tner_pkg::NOTE_W-1:0] out_note,
  input logic [tner_pkg::DUR_W-1:0]         duration,
  input logic [tner_pkg::DUR_W-1:0]         gap,
  input logic                               last,
  input logic                               stop_sound
);

  // A stalled input transaction holds its payload.
  `ASSERT_CLK(a_in_hold, clk, rst,
              in_valid && in_stall |=> in_valid && $stable({command, time_ms, note}),
              "stalled input changed")

  // A stalled result transaction holds its payload.
  `ASSERT_CLK(a_out_hold, clk, rst,
              out_valid && out_stall |=> out_valid && $stable({kind, status, recording,
              count, out_note, duration, gap, last, stop_sound}), "stalled result changed")

  // No new event is taken while a result is pending.
  `ASSERT_CLK(a_busy, clk, rst, out_valid |-> in_stall, "input taken with result pending")

  // A taken playback entry that is not last is followed by the next one.
  `ASSERT_CLK(a_play_next, clk, rst,
              out_valid && !out_stall && kind && !last |-> ##2 (out_valid && kind),
              "playback entry missing")

  // Sound stop comes only with the full report, and recording is off.
  `ASSERT_CLK(a_full_stop, clk, rst,
              out_valid && stop_sound |-> !kind && !recording && status == tner_pkg::ST_FULL,
              "bad sound stop")

endmodule

bind timed_note_event_recorder tner_checker u_tner_checker (.*);
